// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker modules of the grid walk block.
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_ni is high.
`define BGW_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BGW_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/bgw_pkg.sv =====
// Package of the grid walk block: grid geometry, microcode format and program,
// and the request type of the cell store. No dependencies.
package bgw_pkg;

  localparam int GRID_WIDTH   = 4;
  localparam int GRID_HEIGHT  = 8;
  localparam int CELL_COUNT   = GRID_WIDTH * GRID_HEIGHT;
  localparam int WALK_PASSES  = 8;

  localparam int X_W    = $clog2(GRID_WIDTH);
  localparam int Y_W    = $clog2(GRID_HEIGHT);
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int PASS_W = $clog2(WALK_PASSES);
  localparam int UPC_W  = 5;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [7:0]        cell_val_t;
  typedef logic [UPC_W-1:0]  upc_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } pos_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    REG_COUNT_MODE   = 2'd0,
    REG_GATE_MODE    = 2'd1,
    REG_CLAMP_ENABLE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    UOP_WAIT = 3'd0,  // take an item, branch to the bit-mode loop if selected
    UOP_LOAD = 3'd1,  // load the step counter from the byte of dir
    UOP_WALK = 3'd2,  // step toward dir until the counter is zero
    UOP_BIT  = 3'd3,  // one step toward dir if the pass bit is set
    UOP_JUMP = 3'd4,
    UOP_NOP  = 3'd5,
    UOP_READ = 3'd6,  // read the cell at the sweep index
    UOP_EMIT = 3'd7   // load output register, loop to target until last cell
  } uop_e;

  typedef struct packed {
    uop_e uop;
    dir_e dir;
    upc_t target;
  } ucode_t;

  localparam upc_t UA_WAIT     = 5'd0;
  localparam upc_t UA_BIT_LOOP = 5'd10;
  localparam upc_t UA_SWEEP    = 5'd14;
  localparam upc_t UA_READ     = 5'd15;

  localparam cell_t LAST_CELL = CELL_W'(CELL_COUNT - 1);

  typedef struct packed {
    logic      clear;
    logic      rd_en;
    cell_t     rd_addr;
    logic      wr_en;
    cell_t     wr_addr;
    cell_val_t wr_data;
  } cs_req_t;

  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t cw;
    case (addr)
      5'd0:    cw = '{UOP_WAIT, DIR_N, UA_BIT_LOOP};
      5'd1:    cw = '{UOP_LOAD, DIR_N, UA_WAIT};
      5'd2:    cw = '{UOP_WALK, DIR_N, UA_WAIT};
      5'd3:    cw = '{UOP_LOAD, DIR_E, UA_WAIT};
      5'd4:    cw = '{UOP_WALK, DIR_E, UA_WAIT};
      5'd5:    cw = '{UOP_LOAD, DIR_S, UA_WAIT};
      5'd6:    cw = '{UOP_WALK, DIR_S, UA_WAIT};
      5'd7:    cw = '{UOP_LOAD, DIR_W, UA_WAIT};
      5'd8:    cw = '{UOP_WALK, DIR_W, UA_WAIT};
      5'd9:    cw = '{UOP_JUMP, DIR_N, UA_SWEEP};
      5'd10:   cw = '{UOP_BIT,  DIR_N, UA_WAIT};
      5'd11:   cw = '{UOP_BIT,  DIR_E, UA_WAIT};
      5'd12:   cw = '{UOP_BIT,  DIR_S, UA_WAIT};
      5'd13:   cw = '{UOP_BIT,  DIR_W, UA_BIT_LOOP};
      5'd14:   cw = '{UOP_NOP,  DIR_N, UA_WAIT};
      5'd15:   cw = '{UOP_READ, DIR_N, UA_WAIT};
      5'd16:   cw = '{UOP_EMIT, DIR_N, UA_READ};
      default: cw = '{UOP_JUMP, DIR_N, UA_WAIT};
    endcase
    return cw;
  endfunction

  // One move on the torus.
  function automatic pos_t step_pos(pos_t p, dir_e d);
    pos_t n;
    n = p;
    case (d)
      DIR_N: n.y = (p.y == '0) ? Y_W'(GRID_HEIGHT - 1) : p.y - 1'b1;
      DIR_E: n.x = (int'(p.x) + 1 >= GRID_WIDTH) ? '0 : p.x + 1'b1;
      DIR_S: n.y = (int'(p.y) + 1 >= GRID_HEIGHT) ? '0 : p.y + 1'b1;
      DIR_W: n.x = (p.x == '0) ? X_W'(GRID_WIDTH - 1) : p.x - 1'b1;
      default: n = p;
    endcase
    return n;
  endfunction

  function automatic cell_t cell_addr(pos_t p);
    return CELL_W'(p.x) + CELL_W'(p.y) * CELL_W'(GRID_WIDTH);
  endfunction

  function automatic pos_t start_pos(logic [4:0] start);
    cell_t sat;
    pos_t  p;
    sat = (int'(start) > CELL_COUNT - 1) ? LAST_CELL : CELL_W'(start);
    p.x = X_W'(sat % GRID_WIDTH);
    p.y = Y_W'(sat / GRID_WIDTH);
    return p;
  endfunction

  // North is the top byte, west the bottom byte.
  function automatic cell_val_t dir_byte(logic [31:0] w, dir_e d);
    cell_val_t b;
    case (d)
      DIR_N:   b = w[31:24];
      DIR_E:   b = w[23:16];
      DIR_S:   b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/bgw_if.sv =====
// Valid/ready channel interfaces of the grid walk block: input items,
// result words and configuration writes. No dependencies.
interface bgw_in_if;
  logic              valid;
  logic              ready;
  logic [31:0]       word;
  logic signed [5:0] rotate_amount;
  logic [4:0]        start_cell;
  logic [7:0]        intensity;

  modport source (output valid, word, rotate_amount, start_cell, intensity, input ready);
  modport sink   (input valid, word, rotate_amount, start_cell, intensity, output ready);
endinterface

interface bgw_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] cell_index;
  logic [7:0] level;
  logic       gate;
  logic       last;

  modport source (output valid, cell_index, level, gate, last, input ready);
  modport sink   (input valid, cell_index, level, gate, last, output ready);
endinterface

interface bgw_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bgw_cell_store.sv =====
// Cell store of the grid walk block: one 8-bit value per grid cell, with
// per-cell valid bits so that a clear empties every cell at once. Depends on bgw_pkg.
module bgw_cell_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bgw_pkg::cs_req_t    req_i,
  output bgw_pkg::cell_val_t  rd_data_o
);
  import bgw_pkg::*;

  cell_val_t               mem_q [CELL_COUNT];
  logic [CELL_COUNT-1:0]   valid_q;
  cell_val_t               rdata_q;
  logic                    rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // A cell not written since the last clear reads as zero.
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/core/bitword_grid_walk_pattern.sv =====
// Grid walk block: it accepts an item, walks it over the torus in count mode or
// bit mode with one cell store access per step, then sweeps the grid out as 32
// words, with one read and one emit per cell. One item is in work at a time;
// the last word may still wait at the output while the next item enters.
// Depends on bgw_pkg, bgw_if and bgw_cell_store.
module bitword_grid_walk_pattern (
  input  logic      clk_i,
  input  logic      rst_ni,
  bgw_in_if.sink    in_i,
  bgw_out_if.source out_o,
  bgw_cfg_if.sink   cfg_i
);
  import bgw_pkg::*;

  logic count_mode_q, gate_mode_q, clamp_enable_q;

  upc_t              upc_q, upc_d;
  logic [31:0]       word_q, word_d;
  pos_t              pos_q, pos_d;
  cell_val_t         cnt_q, cnt_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  cell_t             idx_q, idx_d;
  cell_val_t         intensity_q, intensity_d;
  logic              pend_q, pend_d;
  cell_t             pend_addr_q, pend_addr_d;

  logic      out_valid_q;
  cell_t     out_cell_q;
  cell_val_t out_level_q;
  logic      out_gate_q, out_last_q;

  ucode_t      cw;
  pos_t        pos_nxt;
  cell_val_t   byte_sel;
  logic        step;
  logic        in_ready;
  logic        out_load;
  logic [63:0] rot_wide;
  cs_req_t     cs_req;
  cell_val_t   rd_data;
  logic [15:0] prod;
  cell_val_t   level;

  assign cw       = ucode_rom(upc_q);
  assign pos_nxt  = step_pos(pos_q, cw.dir);
  assign byte_sel = dir_byte(word_q, cw.dir);
  assign rot_wide = {in_i.word, in_i.word} << in_i.rotate_amount[4:0];

  always_comb begin
    upc_d       = upc_q + 1'b1;
    word_d      = word_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    idx_d       = idx_q;
    intensity_d = intensity_q;
    step        = 1'b0;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    cs_req.clear   = 1'b0;
    cs_req.rd_en   = 1'b0;
    cs_req.rd_addr = cell_addr(pos_nxt);
    cs_req.wr_en   = pend_q;
    cs_req.wr_addr = pend_addr_q;
    cs_req.wr_data = gate_mode_q ? (rd_data ^ 8'h01) : (rd_data + 8'd1);

    case (cw.uop)
      UOP_WAIT: begin
        in_ready = 1'b1;
        upc_d    = upc_q;
        if (in_i.valid) begin
          word_d       = rot_wide[63:32];
          pos_d        = start_pos(in_i.start_cell);
          intensity_d  = in_i.intensity;
          pass_d       = '0;
          idx_d        = '0;
          cs_req.clear = 1'b1;
          upc_d        = count_mode_q ? upc_q + 1'b1 : cw.target;
        end
      end
      UOP_LOAD: cnt_d = byte_sel;
      UOP_WALK: begin
        if (cnt_q != '0) begin
          step  = 1'b1;
          cnt_d = cnt_q - 1'b1;
          upc_d = upc_q;
        end
      end
      UOP_BIT: begin
        step = byte_sel[pass_q];
        if (cw.dir == DIR_W) begin
          pass_d = pass_q + 1'b1;
          if (pass_q != PASS_W'(WALK_PASSES - 1)) begin
            upc_d = cw.target;
          end
        end
      end
      UOP_JUMP: upc_d = cw.target;
      UOP_NOP: ;
      UOP_READ: begin
        cs_req.rd_en   = 1'b1;
        cs_req.rd_addr = idx_q;
      end
      UOP_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (idx_q == LAST_CELL) begin
            upc_d = UA_WAIT;
          end else begin
            idx_d = idx_q + 1'b1;
            upc_d = cw.target;
          end
        end else begin
          upc_d = upc_q;
        end
      end
      default: upc_d = UA_WAIT;
    endcase

    // A step reads the cell it enters now and writes it back next cycle.
    // Consecutive steps never enter the same cell, so no bypass is needed.
    pend_d      = step;
    pend_addr_d = cell_addr(pos_nxt);
    if (step) begin
      pos_d        = pos_nxt;
      cs_req.rd_en = 1'b1;
    end
  end

  bgw_cell_store u_cell_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (cs_req),
    .rd_data_o (rd_data)
  );

  assign prod  = 16'(rd_data) * 16'(intensity_q);
  assign level = (clamp_enable_q && (prod > 16'h00FF)) ? 8'hFF : prod[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q          <= UA_WAIT;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      count_mode_q   <= 1'b1;
      gate_mode_q    <= 1'b1;
      clamp_enable_q <= 1'b1;
    end else begin
      upc_q  <= upc_d;
      pend_q <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_COUNT_MODE:   count_mode_q   <= cfg_i.data;
          REG_GATE_MODE:    gate_mode_q    <= cfg_i.data;
          REG_CLAMP_ENABLE: clamp_enable_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    pos_q       <= pos_d;
    cnt_q       <= cnt_d;
    pass_q      <= pass_d;
    idx_q       <= idx_d;
    intensity_q <= intensity_d;
    pend_addr_q <= pend_addr_d;
    if (out_load) begin
      out_cell_q  <= idx_q;
      out_level_q <= level;
      out_gate_q  <= (rd_data != '0);
      out_last_q  <= (idx_q == LAST_CELL);
    end
  end

  assign in_i.ready       = in_ready;
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.cell_index = 5'(out_cell_q);
  assign out_o.level      = out_level_q;
  assign out_o.gate       = out_gate_q;
  assign out_o.last       = out_last_q;

endmodule

// ===== rtl/core/bgw_checker.sv =====
// Port checker of the grid walk block, bound to the top level.
// Depends on assert_macros.svh and bgw_pkg.
`include "assert_macros.svh"

module bgw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_cell_index_i,
  input logic [7:0] out_level_i,
  input logic       out_gate_i,
  input logic       out_last_i
);
  import bgw_pkg::*;

  // The output register is empty while reset is held.
  `BGW_ASSERT_ANY(a_rst_out_idle, !rst_ni |-> !out_valid_i, "output valid during reset")

  // A stalled word keeps its level.
  `BGW_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_level_i), "stalled output word changed")

  // Once an item is taken, the walk is busy for at least the next cycle.
  `BGW_ASSERT_CLK(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "input accepted twice in a row")

  // The last flag marks exactly the final cell.
  `BGW_ASSERT_CLK(a_last_cell, out_valid_i |-> (out_last_i == (out_cell_index_i == 5'(LAST_CELL))), "last flag on the wrong cell")

  // An empty cell always has a zero level.
  `BGW_ASSERT_CLK(a_gate_level, out_valid_i && !out_gate_i |-> out_level_i == 8'd0, "level set on an empty cell")

endmodule

bind bitword_grid_walk_pattern bgw_checker u_bgw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_cell_index_i (out_o.cell_index),
  .out_level_i      (out_o.level),
  .out_gate_i       (out_o.gate),
  .out_last_i       (out_o.last)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the grid walk block: it drives items, configuration writes
// and output backpressure, and checks every cell word against its own walk predictor.
// Depends on bgw_pkg, the channel interfaces in bgw_if and the top bitword_grid_walk_pattern.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgw_pkg::*;

  localparam int QUIET_LIMIT   = 12000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [31:0]       word;
    logic signed [5:0] rotate_amount;
    logic [4:0]        start_cell;
    logic [7:0]        intensity;
  } walk_item_t;

  typedef struct packed {
    logic [4:0] cell_index;
    logic [7:0] level;
    logic       gate;
    logic       last;
  } cell_word_t;

  typedef struct packed {
    cfg_reg_e index;
    logic     data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  bgw_in_if  in_bus ();
  bgw_out_if out_bus ();
  bgw_cfg_if cfg_bus ();

  bitword_grid_walk_pattern dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Copy of the configuration as the block should hold it.
  logic walk_by_count = 1'b1;
  logic toggle_marks  = 1'b1;
  logic clamp_level   = 1'b1;

  walk_item_t items_pending[$];
  cell_word_t cell_words_due[$];
  reg_write_t reg_writes[$];

  int src_idle_pct = 23;
  int snk_idle_pct = 49;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int items_taken = 0;
  int words_checked = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // Corner items: zero and full words, rotations at both ends (the pattern for -32
  // leaves the word as it is), extreme start cells and intensities.
  walk_item_t corner_items[12] = '{
    '{32'h0000_0000,  6'sd0,  5'd0,  8'd255},
    '{32'hFFFF_FFFF,  6'sd0,  5'd31, 8'd255},
    '{32'h0102_0304,  6'sd0,  5'd5,  8'd1},
    '{32'h8000_0001,  6'sd1,  5'd0,  8'd128},
    '{32'h8000_0001, -6'sd1,  5'd10, 8'd3},
    '{32'h1234_5678, -6'sd32, 5'd17, 8'd200},
    '{32'h1234_5678,  6'sd31, 5'd31, 8'd0},
    '{32'h1234_5678, -6'sd31, 5'd3,  8'd2},
    '{32'hFF00_0000,  6'sd0,  5'd4,  8'd255},
    '{32'h00FF_00FF,  6'sd0,  5'd28, 8'd129},
    '{32'hAA55_AA55,  6'sd8,  5'd12, 8'd77},
    '{32'h0000_FF00,  6'sd16, 5'd0,  8'd1}
  };

  // Walks one item over a cleared torus and queues the 32 cell words it yields.
  function automatic void predict_pattern(walk_item_t it);
    logic [31:0] rot;
    logic [4:0]  amt;
    logic [7:0]  dir_steps [4];
    logic [7:0]  grid [CELL_COUNT];
    int unsigned px, py, start, idx, passes, n, prod;
    cell_word_t  cw;
    amt = it.rotate_amount[4:0];
    rot = (amt == 5'd0) ? it.word : ((it.word << amt) | (it.word >> (32 - amt)));
    dir_steps[0] = rot[31:24];
    dir_steps[1] = rot[23:16];
    dir_steps[2] = rot[15:8];
    dir_steps[3] = rot[7:0];
    foreach (grid[i]) grid[i] = 8'd0;
    start = it.start_cell;
    if (start > CELL_COUNT - 1) start = CELL_COUNT - 1;
    px = start % GRID_WIDTH;
    py = start / GRID_WIDTH;
    passes = walk_by_count ? 1 : WALK_PASSES;
    for (int p = 0; p < passes; p++) begin
      for (int d = 0; d < 4; d++) begin
        n = walk_by_count ? dir_steps[d] : dir_steps[d][p];
        for (int s = 0; s < n; s++) begin
          case (dir_e'(d))
            DIR_N: py = (py == 0) ? GRID_HEIGHT - 1 : py - 1;
            DIR_E: px = (px + 1 >= GRID_WIDTH) ? 0 : px + 1;
            DIR_S: py = (py + 1 >= GRID_HEIGHT) ? 0 : py + 1;
            default: px = (px == 0) ? GRID_WIDTH - 1 : px - 1;
          endcase
          idx = px + py * GRID_WIDTH;
          if (toggle_marks) grid[idx] = grid[idx] ^ 8'd1;
          else grid[idx] = grid[idx] + 8'd1;
        end
      end
    end
    for (int i = 0; i < CELL_COUNT; i++) begin
      prod = grid[i] * it.intensity;
      cw.cell_index = 5'(i);
      cw.level = (clamp_level && prod > 255) ? 8'hFF : prod[7:0];
      cw.gate = (grid[i] != 8'd0);
      cw.last = (i == CELL_COUNT - 1);
      cell_words_due.push_back(cw);
    end
  endfunction

  // Mostly short step counts keep count-mode walks brief; a quarter of the bytes are
  // fully random so long walks and every bit still show up.
  function automatic walk_item_t random_item();
    walk_item_t it;
    for (int b = 0; b < 4; b++)
      it.word[8*b +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24));
    it.rotate_amount = 6'($urandom);
    it.start_cell = 5'($urandom_range(31));
    it.intensity = ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom);
    return it;
  endfunction

  // Item driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid         <= 1'b0;
      in_bus.word          <= '0;
      in_bus.rotate_amount <= '0;
      in_bus.start_cell    <= '0;
      in_bus.intensity     <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_pattern('{in_bus.word, in_bus.rotate_amount, in_bus.start_cell,
                          in_bus.intensity});
        items_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (items_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          walk_item_t it;
          it = items_pending.pop_front();
          in_bus.valid         <= 1'b1;
          in_bus.word          <= it.word;
          in_bus.rotate_amount <= it.rotate_amount;
          in_bus.start_cell    <= it.start_cell;
          in_bus.intensity     <= it.intensity;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Configuration driver; the predictor's copy follows each accepted write.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bus.valid <= 1'b0;
      cfg_bus.index <= REG_COUNT_MODE;
      cfg_bus.data  <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_e'(cfg_bus.index))
          REG_COUNT_MODE:   walk_by_count = cfg_bus.data;
          REG_GATE_MODE:    toggle_marks = cfg_bus.data;
          REG_CLAMP_ENABLE: clamp_level = cfg_bus.data;
          default: ;
        endcase
      end
      if (!cfg_bus.valid || cfg_bus.ready) begin
        if (reg_writes.size() != 0) begin
          reg_write_t w;
          w = reg_writes.pop_front();
          cfg_bus.valid <= 1'b1;
          cfg_bus.index <= w.index;
          cfg_bus.data  <= w.data;
        end else begin
          cfg_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver backpressure, including the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (cell_words_due.size() == 0) begin
          $error("cell word %0d arrived with nothing expected", out_bus.cell_index);
          errors++;
        end else begin
          cell_word_t exp_w;
          exp_w = cell_words_due.pop_front();
          words_checked++;
          if (out_bus.cell_index !== exp_w.cell_index) begin
            $error("cell_index: expected %0d, got %0d", exp_w.cell_index, out_bus.cell_index);
            errors++;
          end
          if (out_bus.level !== exp_w.level) begin
            $error("level: expected %0d, got %0d", exp_w.level, out_bus.level);
            errors++;
          end
          if (out_bus.gate !== exp_w.gate) begin
            $error("gate: expected %0b, got %0b", exp_w.gate, out_bus.gate);
            errors++;
          end
          if (out_bus.last !== exp_w.last) begin
            $error("last: expected %0b, got %0b", exp_w.last, out_bus.last);
            errors++;
          end
        end
      end
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted word on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain_block();
    while (items_pending.size() != 0 || in_bus.valid || cell_words_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(logic by_count, logic toggle, logic clamp, int src_pct,
                           int snk_pct, bit with_corners, int n_random, bit with_hold);
    drain_block();
    reg_writes.push_back('{REG_COUNT_MODE, by_count});
    reg_writes.push_back('{REG_GATE_MODE, toggle});
    reg_writes.push_back('{REG_CLAMP_ENABLE, clamp});
    while (reg_writes.size() != 0 || cfg_bus.valid) @(negedge clk_i);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    if (with_corners)
      foreach (corner_items[i]) items_pending.push_back(corner_items[i]);
    for (int i = 0; i < n_random; i++) items_pending.push_back(random_item());
    if (with_hold) holds_asked++;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_phase(1'b1, 1'b1, 1'b1, 23, 49, 1'b1, 50, 1'b0);
    run_phase(1'b0, 1'b0, 1'b0, 23, 49, 1'b1, 50, 1'b1);
    run_phase(1'b1, 1'b0, 1'b0, 23, 49, 1'b0, 55, 1'b0);
    run_phase(1'b0, 1'b1, 1'b1, 49, 23, 1'b0, 55, 1'b0);
    run_phase(1'b1, 1'b0, 1'b1, 49, 23, 1'b0, 55, 1'b1);
    run_phase(1'b0, 1'b0, 1'b1, 49, 23, 1'b0, 55, 1'b0);
    run_phase(1'b1, 1'b1, 1'b0, 0, 0, 1'b0, 55, 1'b0);
    run_phase(1'b0, 1'b1, 1'b0, 0, 0, 1'b0, 55, 1'b0);
    drain_block();

    $display("summary: %0d items walked under 8 register settings in both walk modes,",
             items_taken);
    $display("summary: %0d cell words checked, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== bitword_grid_walk_pattern.f =====
+incdir+rtl/core
rtl/core/bgw_pkg.sv
rtl/core/bgw_if.sv
rtl/core/bgw_cell_store.sv
rtl/core/bitword_grid_walk_pattern.sv
rtl/core/bgw_checker.sv
tb/sv/tb.sv
